// ----- src/two_digit_seven_segment_pwm_mux_assert.svh -----
// ---------------------------------------------------------------------------
// two-digit seven-segment driver assertion macros
// shared property shapes for the port checker
// ---------------------------------------------------------------------------
`ifndef TWO_DIGIT_SEVEN_SEGMENT_PWM_MUX_ASSERT_SVH
`define TWO_DIGIT_SEVEN_SEGMENT_PWM_MUX_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SSPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sspm_pkg.sv -----
// ---------------------------------------------------------------------------
// sspm_pkg
// shared codes, types and segment table of the seven-segment driver
// ---------------------------------------------------------------------------
package sspm_pkg;

	// action codes of an input word
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_HEX  = 2'd1;
	localparam logic [1:0] ACT_RAW  = 2'd2;

	// register indexes (paddr[2])
	localparam logic REG_BRIGHTNESS = 1'b0;
	localparam logic REG_POLARITY   = 1'b1;

	localparam logic [6:0] BRIGHTNESS_MAX = 7'd100;

	typedef struct packed {
		logic [6:0] brightness;
		logic       anode;
	} cfg_t;

	typedef struct packed {
		logic       load_hex;
		logic       load_raw;
		logic [7:0] left_value;
		logic [7:0] right_value;
	} load_t;

	// hex value to segments a..g, dp off; 16 and up blank
	function automatic logic [7:0] hex_to_pattern(input logic [7:0] v);
		logic [7:0] p;
		p = 8'h00;
		if (v[7:4] == 4'h0) begin
			unique case (v[3:0])
				4'h0: p = 8'h3F;
				4'h1: p = 8'h06;
				4'h2: p = 8'h5B;
				4'h3: p = 8'h4F;
				4'h4: p = 8'h66;
				4'h5: p = 8'h6D;
				4'h6: p = 8'h7D;
				4'h7: p = 8'h07;
				4'h8: p = 8'h7F;
				4'h9: p = 8'h6F;
				4'hA: p = 8'h77;
				4'hB: p = 8'h7C;
				4'hC: p = 8'h39;
				4'hD: p = 8'h5E;
				4'hE: p = 8'h79;
				4'hF: p = 8'h71;
			endcase
		end
		return p;
	endfunction

endpackage

// ----- src/sspm_apb_regs.sv -----
// ---------------------------------------------------------------------------
// sspm_apb_regs
// apb register file: brightness (saturating) and polarity
// ---------------------------------------------------------------------------
module sspm_apb_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output sspm_pkg::cfg_t cfg
);
	import sspm_pkg::*;

	logic [6:0] brightness_q;
	logic       anode_q;
	logic       wr_en;
	logic [6:0] wr_bright;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// saturate brightness writes
	assign wr_bright = (pwdata[6:0] > BRIGHTNESS_MAX) ? BRIGHTNESS_MAX : pwdata[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHTNESS_MAX;
			anode_q      <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_BRIGHTNESS: brightness_q <= wr_bright;
				REG_POLARITY:   anode_q      <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		prdata = 32'h0;
		unique case (paddr[2])
			REG_BRIGHTNESS: prdata = {25'h0, brightness_q};
			REG_POLARITY:   prdata = {31'h0, anode_q};
		endcase
	end

	assign cfg.brightness = brightness_q;
	assign cfg.anode      = anode_q;

endmodule

// ----- src/sspm_digit_load.sv -----
// ---------------------------------------------------------------------------
// sspm_digit_load
// digit pattern registers with hex decode or raw mask load
// ---------------------------------------------------------------------------
module sspm_digit_load (
	input  logic           clk,
	input  logic           arst_n,
	input  sspm_pkg::load_t ld,
	output logic [7:0]     left_pattern,
	output logic [7:0]     right_pattern
);
	import sspm_pkg::*;

	logic [7:0] left_q;
	logic [7:0] right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= 8'h00;
			right_q <= 8'h00;
		end else if (ld.load_hex) begin
			left_q  <= hex_to_pattern(ld.left_value);
			right_q <= hex_to_pattern(ld.right_value);
		end else if (ld.load_raw) begin
			left_q  <= ld.left_value;
			right_q <= ld.right_value;
		end
	end

	assign left_pattern  = left_q;
	assign right_pattern = right_q;

endmodule

// ----- src/sspm_pwm_scan.sv -----
// ---------------------------------------------------------------------------
// sspm_pwm_scan
// pwm slice counter, digit turn and pin level generation per tick
// ---------------------------------------------------------------------------
module sspm_pwm_scan #(
	parameter int PWM_SLICES = 100
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tick,
	input  sspm_pkg::cfg_t cfg,
	input  logic [7:0]     left_pattern,
	input  logic [7:0]     right_pattern,
	output logic [7:0]     seg_levels,
	output logic           left_level,
	output logic           right_level
);
	import sspm_pkg::*;

	localparam int SW = $clog2(PWM_SLICES);
	localparam logic [SW-1:0] SLICE_LAST = SW'(PWM_SLICES - 1);

	logic [SW-1:0] slice_q;
	logic          left_turn_q;
	logic          lit;
	logic [7:0]    mask;
	logic          left_on;
	logic          right_on;

	assign lit = {{(8-SW){1'b0}}, slice_q} < {1'b0, cfg.brightness};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q     <= '0;
			left_turn_q <= 1'b1;
		end else if (tick) begin
			slice_q     <= (slice_q == SLICE_LAST) ? '0 : slice_q + 1'b1;
			left_turn_q <= ~left_turn_q;
		end
	end

	always_comb begin
		mask     = 8'h00;
		left_on  = 1'b0;
		right_on = 1'b0;
		if (lit) begin
			if (left_turn_q) begin
				mask    = left_pattern;
				left_on = 1'b1;
			end else begin
				mask     = right_pattern;
				right_on = 1'b1;
			end
		end
	end

	// anode: segments active low, enables active high; cathode the reverse
	assign seg_levels  = cfg.anode ? ~mask : mask;
	assign left_level  = ~(left_on ^ cfg.anode);
	assign right_level = ~(right_on ^ cfg.anode);

endmodule

// ----- src/two_digit_seven_segment_pwm_mux.sv -----
// ---------------------------------------------------------------------------
// two_digit_seven_segment_pwm_mux
// two-digit multiplexed seven-segment driver with pwm brightness
// ---------------------------------------------------------------------------
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+-------------------------------------
//   item     | item_valid / item_ready       | action, left_value, right_value
//   result   | result_valid / result_ready   | segment_levels, left/right_enable_level
//   config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// one word per cycle while no tick word waits on a stalled result; a tick word
// passes the input register, then shows its result from the result register
// the input register and the result register each hold one word; load and
// ignored words retire from the input register without touching the result side
// a stalled result only holds back a tick word behind it; item_ready stays high
// whenever result_ready is high
// reset (arst_n low) clears patterns to blank, slice to zero, turn to left,
// brightness to full and polarity to common cathode
// ---------------------------------------------------------------------------
module two_digit_seven_segment_pwm_mux #(
	parameter int PWM_SLICES = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  left_value,
	input  logic [7:0]  right_value,
	// result channel
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  segment_levels,
	output logic        left_enable_level,
	output logic        right_enable_level,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sspm_pkg::*;

	// input register
	logic       valid_s1;
	logic [1:0] action_s1;
	logic [7:0] left_s1;
	logic [7:0] right_s1;

	// result register
	logic       result_valid_q;
	logic [7:0] seg_q;
	logic       left_en_q;
	logic       right_en_q;

	cfg_t       cfg;
	load_t      ld;
	logic [7:0] left_pattern;
	logic [7:0] right_pattern;
	logic [7:0] seg_levels;
	logic       left_level;
	logic       right_level;

	logic       is_tick_s1;
	logic       out_free;
	logic       go_s1;
	logic       tick;
	logic       take_in;

	sspm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the word in the input register retires when it is a load or ignored
	// word, or a tick and the result register can take a new word
	assign is_tick_s1 = (action_s1 == ACT_TICK);
	assign out_free   = ~result_valid_q | result_ready;
	assign go_s1      = valid_s1 & (~is_tick_s1 | out_free);
	assign tick       = go_s1 & is_tick_s1;

	assign item_ready = ~valid_s1 | go_s1;
	assign take_in    = item_valid & item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// payload of the input register, no reset needed
	always_ff @(posedge clk) begin
		if (take_in) begin
			action_s1 <= action;
			left_s1   <= left_value;
			right_s1  <= right_value;
		end
	end

	// pattern loads happen when the load word retires
	assign ld.load_hex    = go_s1 & (action_s1 == ACT_HEX);
	assign ld.load_raw    = go_s1 & (action_s1 == ACT_RAW);
	assign ld.left_value  = left_s1;
	assign ld.right_value = right_s1;

	sspm_digit_load u_load (
		.clk           (clk),
		.arst_n        (arst_n),
		.ld            (ld),
		.left_pattern  (left_pattern),
		.right_pattern (right_pattern)
	);

	sspm_pwm_scan #(
		.PWM_SLICES (PWM_SLICES)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (tick),
		.cfg           (cfg),
		.left_pattern  (left_pattern),
		.right_pattern (right_pattern),
		.seg_levels    (seg_levels),
		.left_level    (left_level),
		.right_level   (right_level)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= tick;
		end
	end

	// result payload, loaded with each tick
	always_ff @(posedge clk) begin
		if (tick) begin
			seg_q      <= seg_levels;
			left_en_q  <= left_level;
			right_en_q <= right_level;
		end
	end

	assign result_valid       = result_valid_q;
	assign segment_levels     = seg_q;
	assign left_enable_level  = left_en_q;
	assign right_enable_level = right_en_q;

endmodule

// ----- src/sspm_checker.sv -----
// ---------------------------------------------------------------------------
// sspm_checker
// port-level checks of the seven-segment driver, bound to the top level
// ---------------------------------------------------------------------------
`include "two_digit_seven_segment_pwm_mux_assert.svh"

module sspm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [7:0]  segment_levels,
	input logic        left_enable_level,
	input logic        right_enable_level
);

	// a stalled result word holds
	`SSPM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
		result_valid && $stable(segment_levels) && $stable(left_enable_level)
		&& $stable(right_enable_level), "result word changed while stalled")

	// both enables inactive at cathode polarity means all segments off
	`SSPM_ASSERT_NOW(a_blank_cathode,
		result_valid && left_enable_level && right_enable_level,
		segment_levels == 8'h00, "cathode blank slice drives segments")

	// both enables inactive at anode polarity means all segment pins high
	`SSPM_ASSERT_NOW(a_blank_anode,
		result_valid && !left_enable_level && !right_enable_level,
		segment_levels == 8'hFF, "anode blank slice drives segments")

	// a drained result side never holds back the item side
	`SSPM_ASSERT_NOW(a_ready_drained, result_ready, item_ready,
		"item side stalled while result side drains")

endmodule

bind two_digit_seven_segment_pwm_mux sspm_checker u_sspm_checker (.*);
